[design/sdsm_pkg.sv]
package sdsm_pkg;

    // field widths
    localparam int AXIS_W  = 16;
    localparam int MAG_W   = 15;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int CUBE_W  = 3 * MAG_W;
    localparam int QUO_W   = 15;
    localparam int NUM_W   = CUBE_W + QUO_W;
    localparam int TRIG_W  = 8;
    localparam int OUT_W   = 16;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;
    localparam int LANES   = 2;

    // one quotient bit per divider stage
    localparam int DIV_STEPS = QUO_W;

    // edges from an accepted item to the edge that takes its result
    localparam int PIPE_DEPTH = DIV_STEPS + 5;

    localparam logic [MAG_W-1:0] STICK_MAX = 15'd32767;
    localparam logic [QUO_W-1:0] WHEEL_MAX = 15'd24831;

    // register indexes, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_SINGLE   = 2'd0,
        REG_LINEAR   = 2'd1,
        REG_LEFT_DZ  = 2'd2,
        REG_RIGHT_DZ = 2'd3
    } reg_idx_t;

    // what travels beside the two axis lanes
    typedef struct packed {
        logic              neg_l;
        logic              neg_r;
        logic [TRIG_W-1:0] accel;
        logic [TRIG_W-1:0] brake;
    } side_t;

endpackage

[design/sdsm_divider.sv]
module sdsm_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [sdsm_pkg::NUM_W-1:0]   in_num [sdsm_pkg::LANES],
    input  logic [sdsm_pkg::CUBE_W-1:0]  in_den [sdsm_pkg::LANES],
    input  sdsm_pkg::side_t              in_side,
    output logic                         out_valid,
    output logic [sdsm_pkg::QUO_W-1:0]   out_quo [sdsm_pkg::LANES],
    output sdsm_pkg::side_t              out_side
);
    import sdsm_pkg::*;

    // per-stage pipeline registers
    logic [DIV_STEPS-1:0] vld_reg;
    side_t                side_reg [DIV_STEPS];
    logic [NUM_W-1:0]     rem_reg  [LANES][DIV_STEPS];
    logic [CUBE_W-1:0]    den_reg  [LANES][DIV_STEPS];
    logic [QUO_W-1:0]     quo_reg  [LANES][DIV_STEPS];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DIV_STEPS-2:0], in_valid};
        end
    end

    // side data follows the valid bits
    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int s = 1; s < DIV_STEPS; s++)
        begin
            side_reg[s] <= side_reg[s-1];
        end
    end

    // restoring division, one quotient bit per stage, msb first
    for (genvar ln = 0; ln < LANES; ln++)
    begin : g_lane
        for (genvar st = 0; st < DIV_STEPS; st++)
        begin : g_step
            localparam int SHIFT = DIV_STEPS - 1 - st;
            logic [NUM_W-1:0]  rem_src;
            logic [CUBE_W-1:0] den_src;
            logic [QUO_W-1:0]  quo_src;
            logic [NUM_W-1:0]  den_sh;
            logic              fits;
            logic [NUM_W-1:0]  rem_next;
            logic [QUO_W-1:0]  quo_next;

            if (st == 0)
            begin : g_first
                assign rem_src = in_num[ln];
                assign den_src = in_den[ln];
                assign quo_src = '0;
            end
            else
            begin : g_rest
                assign rem_src = rem_reg[ln][st-1];
                assign den_src = den_reg[ln][st-1];
                assign quo_src = quo_reg[ln][st-1];
            end

            always_comb
            begin
                den_sh   = {{(NUM_W-CUBE_W){1'b0}}, den_src} << SHIFT;
                fits     = rem_src >= den_sh;
                rem_next = fits ? (rem_src - den_sh) : rem_src;
                quo_next = {quo_src[QUO_W-2:0], fits};
            end

            always_ff @(posedge clk)
            begin
                rem_reg[ln][st] <= rem_next;
                den_reg[ln][st] <= den_src;
                quo_reg[ln][st] <= quo_next;
            end
        end

        assign out_quo[ln] = quo_reg[ln][DIV_STEPS-1];
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

endmodule

[design/stick_deadzone_steering_mapper.sv]
// Stick to steering mapper: two signed stick axes become one steering
// value after a per-axis deadzone and a cubic or linear response curve;
// the two 8-bit triggers are widened by a left shift of eight.
// Input items: an item is taken at each rising edge with start high and
// busy low. busy is tied low, so an item may be offered in every cycle.
// Results: done is high for exactly one cycle while wheel, accel and
// brake hold the result; the receiver takes it at the end of that cycle.
// Pipeline: from the accepting edge to the edge that takes the result, an
// item passes four stages for magnitude, deadzone and the products,
// fifteen stages of a restoring divider that gives one quotient bit per
// stage, and the output register. Throughput is one item per cycle.
// Configuration: APB at byte addresses 0, 4, 8, 12 for single stick
// mode, linear mode, left and right deadzone; pready is always high.
// Write only while no item is in flight.
// Reset: rst_n clears config and valid bits and empties the pipeline.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module stick_deadzone_steering_mapper (
    input  logic                                clk,
    input  logic                                rst_n,
    // item channel
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sdsm_pkg::AXIS_W-1:0]  left_axis,
    input  logic signed [sdsm_pkg::AXIS_W-1:0]  right_axis,
    input  logic [sdsm_pkg::TRIG_W-1:0]         accel_trigger,
    input  logic [sdsm_pkg::TRIG_W-1:0]         brake_trigger,
    // result channel
    output logic                                done,
    output logic signed [sdsm_pkg::OUT_W-1:0]   wheel,
    output logic [sdsm_pkg::OUT_W-1:0]          accel,
    output logic [sdsm_pkg::OUT_W-1:0]          brake,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sdsm_pkg::ADDR_W-1:0]         paddr,
    input  logic [sdsm_pkg::DATA_W-1:0]         pwdata,
    output logic [sdsm_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import sdsm_pkg::*;

    // configuration registers
    logic              single_reg;
    logic              linear_reg;
    logic [MAG_W-1:0]  left_dz_reg;
    logic [MAG_W-1:0]  right_dz_reg;
    reg_idx_t          cfg_idx;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_reg   <= 1'b0;
            linear_reg   <= 1'b0;
            left_dz_reg  <= '0;
            right_dz_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_SINGLE:   single_reg   <= pwdata[0];
                REG_LINEAR:   linear_reg   <= pwdata[0];
                REG_LEFT_DZ:  left_dz_reg  <= pwdata[MAG_W-1:0];
                REG_RIGHT_DZ: right_dz_reg <= pwdata[MAG_W-1:0];
                default:      single_reg   <= single_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (cfg_idx)
            REG_SINGLE:   prdata = {{(DATA_W-1){1'b0}}, single_reg};
            REG_LINEAR:   prdata = {{(DATA_W-1){1'b0}}, linear_reg};
            REG_LEFT_DZ:  prdata = {{(DATA_W-MAG_W){1'b0}}, left_dz_reg};
            REG_RIGHT_DZ: prdata = {{(DATA_W-MAG_W){1'b0}}, right_dz_reg};
            default:      prdata = '0;
        endcase
    end

    // pipeline valid bits
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic div_vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= start && !busy;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
        end
    end

    // side data through the product stages
    side_t side1_reg, side2_reg, side3_reg, side4_reg;
    side_t side_next;

    always_comb
    begin
        side_next.neg_l = left_axis[AXIS_W-1];
        side_next.neg_r = right_axis[AXIS_W-1];
        side_next.accel = accel_trigger;
        side_next.brake = brake_trigger;
    end

    always_ff @(posedge clk)
    begin
        side1_reg <= side_next;
        side2_reg <= side1_reg;
        side3_reg <= side2_reg;
        side4_reg <= side3_reg;
    end

    logic [AXIS_W-1:0] axis_in [LANES];
    logic [MAG_W-1:0]  dz_lane [LANES];

    assign axis_in[0] = left_axis;
    assign axis_in[1] = right_axis;
    assign dz_lane[0] = left_dz_reg;
    assign dz_lane[1] = right_dz_reg;

    // per-lane stage registers
    logic [MAG_W-1:0]  num1_reg  [LANES];
    logic [MAG_W-1:0]  den1_reg  [LANES];
    logic [MAG_W-1:0]  num2_reg  [LANES];
    logic [MAG_W-1:0]  den2_reg  [LANES];
    logic [SQ_W-1:0]   nsq2_reg  [LANES];
    logic [SQ_W-1:0]   dsq2_reg  [LANES];
    logic [CUBE_W-1:0] ncu3_reg  [LANES];
    logic [CUBE_W-1:0] dcu3_reg  [LANES];
    logic [NUM_W-1:0]  nfull_reg [LANES];
    logic [CUBE_W-1:0] dfull_reg [LANES];

    for (genvar ln = 0; ln < LANES; ln++)
    begin : g_lane
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic              dead;
        logic [MAG_W-1:0]  num_next;
        logic [MAG_W-1:0]  den_next;
        logic [CUBE_W-1:0] ncu_next;
        logic [CUBE_W-1:0] dcu_next;

        // stage 1: clipped magnitude and deadzone; dead axes divide 0 by 1
        always_comb
        begin
            neg = axis_in[ln][AXIS_W-1];
            if (neg && axis_in[ln][MAG_W-1:0] == '0)
            begin
                mag = STICK_MAX;
            end
            else if (neg)
            begin
                mag = ~axis_in[ln][MAG_W-1:0] + MAG_W'(1);
            end
            else
            begin
                mag = axis_in[ln][MAG_W-1:0];
            end
            dead = mag <= dz_lane[ln];
            if (dead)
            begin
                num_next = '0;
                den_next = MAG_W'(1);
            end
            else
            begin
                num_next = mag - dz_lane[ln];
                den_next = STICK_MAX - dz_lane[ln];
            end
        end

        // stage 3: cube, or plain value in linear mode
        always_comb
        begin
            if (linear_reg)
            begin
                ncu_next = CUBE_W'(num2_reg[ln]);
                dcu_next = CUBE_W'(den2_reg[ln]);
            end
            else
            begin
                ncu_next = nsq2_reg[ln] * num2_reg[ln];
                dcu_next = dsq2_reg[ln] * den2_reg[ln];
            end
        end

        always_ff @(posedge clk)
        begin
            num1_reg[ln]  <= num_next;
            den1_reg[ln]  <= den_next;
            // stage 2: squares
            num2_reg[ln]  <= num1_reg[ln];
            den2_reg[ln]  <= den1_reg[ln];
            nsq2_reg[ln]  <= num1_reg[ln] * num1_reg[ln];
            dsq2_reg[ln]  <= den1_reg[ln] * den1_reg[ln];
            ncu3_reg[ln]  <= ncu_next;
            dcu3_reg[ln]  <= dcu_next;
            // stage 4: scale the numerator to the wheel range
            nfull_reg[ln] <= ncu3_reg[ln] * WHEEL_MAX;
            dfull_reg[ln] <= dcu3_reg[ln];
        end
    end

    // quotient pipeline
    logic [QUO_W-1:0] quo [LANES];
    side_t            div_side;

    sdsm_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld4_reg),
        .in_num    (nfull_reg),
        .in_den    (dfull_reg),
        .in_side   (side4_reg),
        .out_valid (div_vld),
        .out_quo   (quo),
        .out_side  (div_side)
    );

    // sign, combine, average toward zero; single stick mode takes the left lane
    logic signed [OUT_W:0]   left_val;
    logic signed [OUT_W:0]   right_val;
    logic signed [OUT_W:0]   sum_val;
    logic signed [OUT_W:0]   avg_val;
    logic signed [OUT_W-1:0] wheel_next;

    always_comb
    begin
        left_val  = div_side.neg_l ? -$signed({2'b00, quo[0]})
                                   :  $signed({2'b00, quo[0]});
        right_val = div_side.neg_r ? -$signed({2'b00, quo[1]})
                                   :  $signed({2'b00, quo[1]});
        sum_val   = left_val + right_val;
        avg_val   = (sum_val + $signed({{OUT_W{1'b0}}, sum_val[OUT_W]})) >>> 1;
        wheel_next = single_reg ? left_val[OUT_W-1:0] : avg_val[OUT_W-1:0];
    end

    // output register
    logic                    done_reg;
    logic signed [OUT_W-1:0] wheel_reg;
    logic [OUT_W-1:0]        accel_reg;
    logic [OUT_W-1:0]        brake_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        wheel_reg <= wheel_next;
        accel_reg <= {div_side.accel, {(OUT_W-TRIG_W){1'b0}}};
        brake_reg <= {div_side.brake, {(OUT_W-TRIG_W){1'b0}}};
    end

    assign done  = done_reg;
    assign wheel = wheel_reg;
    assign accel = accel_reg;
    assign brake = brake_reg;

    // every accepted item gives exactly one result, a fixed time later;
    // history from before the first edges counts as no item
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done == ($past(start && !busy && rst_n, PIPE_DEPTH) === 1'b1))
        else $error("result strobe does not match accepted items");

    // the steering value never leaves the curve's range
    a_wheel_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (wheel <= $signed({1'b0, WHEEL_MAX}) &&
                  wheel >= -$signed({1'b0, WHEEL_MAX})))
        else $error("wheel out of range");

    // quotients stay within the scale at the divider output
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_vld |-> (quo[0] <= WHEEL_MAX && quo[1] <= WHEEL_MAX))
        else $error("divider quotient above full scale");

endmodule
